// File: hdl/i2cbe_pkg.sv
// types, command codes and microcode layout for the i2c master bit engine
// no dependencies; used by every module under hdl
`default_nettype none

package i2cbe_pkg;

    // command codes carried in req_type
    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_STOP     = 3'd1;
    localparam logic [2:0] REQ_SEND     = 3'd2;
    localparam logic [2:0] REQ_RECV     = 3'd3;
    localparam logic [2:0] REQ_SEND_ACK = 3'd4;
    localparam logic [2:0] REQ_RECV_ACK = 3'd5;

    // microcode store layout
    localparam int UADDR_W = 5;
    localparam logic [UADDR_W-1:0] UA_START    = 5'd0;
    localparam logic [UADDR_W-1:0] UA_STOP     = 5'd3;
    localparam logic [UADDR_W-1:0] UA_SEND_ACK = 5'd6;
    localparam logic [UADDR_W-1:0] UA_RECV_ACK = 5'd9;
    localparam logic [UADDR_W-1:0] UA_SEND     = 5'd12;
    localparam logic [UADDR_W-1:0] UA_RECV     = 5'd15;
    localparam logic [UADDR_W-1:0] UA_LAST     = 5'd17;

    localparam logic [2:0] BIT_CNT_DONE = 3'd7;

    typedef enum logic [1:0] {
        SDA_LO,
        SDA_HI,
        SDA_TX,
        SDA_ACK
    } sda_src_t;

    typedef enum logic [1:0] {
        RX_NONE,
        RX_BYTE,
        RX_ACK
    } rx_sel_t;

    // one control word per segment
    typedef struct packed {
        logic               scl;
        sda_src_t           sda_src;
        logic               drive;
        rx_sel_t            rx_sel;
        logic               last;
        logic               loop;
        logic [UADDR_W-1:0] target;
    } ucode_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic   load;
        logic   shift;
        logic   emit;
        ucode_t word;
    } dp_ctl_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    function automatic logic req_known(input logic [2:0] req);
        logic ok;
        case (req)
            REQ_START, REQ_STOP, REQ_SEND, REQ_RECV, REQ_SEND_ACK, REQ_RECV_ACK: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [UADDR_W-1:0] req_entry(input logic [2:0] req);
        logic [UADDR_W-1:0] a;
        case (req)
            REQ_START:    a = UA_START;
            REQ_STOP:     a = UA_STOP;
            REQ_SEND:     a = UA_SEND;
            REQ_RECV:     a = UA_RECV;
            REQ_SEND_ACK: a = UA_SEND_ACK;
            REQ_RECV_ACK: a = UA_RECV_ACK;
            default:      a = UA_START;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: hdl/i2cbe_rom.sv
// microcode store: one control word per line segment of every command
// depends on i2cbe_pkg
`default_nettype none

module i2cbe_rom (
    input  wire logic [i2cbe_pkg::UADDR_W-1:0] addr,
    output i2cbe_pkg::ucode_t                  word
);

    always_comb begin
        case (addr)
            // start: (1,1) (1,0) (0,0)
            5'd0:  word = '{1'b1, i2cbe_pkg::SDA_HI,  1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd1:  word = '{1'b1, i2cbe_pkg::SDA_LO,  1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd2:  word = '{1'b0, i2cbe_pkg::SDA_LO,  1'b1, i2cbe_pkg::RX_NONE, 1'b1, 1'b0, 5'd0};
            // stop: (0,0) (1,0) (1,1)
            5'd3:  word = '{1'b0, i2cbe_pkg::SDA_LO,  1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd4:  word = '{1'b1, i2cbe_pkg::SDA_LO,  1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd5:  word = '{1'b1, i2cbe_pkg::SDA_HI,  1'b1, i2cbe_pkg::RX_NONE, 1'b1, 1'b0, 5'd0};
            // send ack
            5'd6:  word = '{1'b0, i2cbe_pkg::SDA_ACK, 1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd7:  word = '{1'b1, i2cbe_pkg::SDA_ACK, 1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd8:  word = '{1'b0, i2cbe_pkg::SDA_ACK, 1'b1, i2cbe_pkg::RX_NONE, 1'b1, 1'b0, 5'd0};
            // receive ack, sda released
            5'd9:  word = '{1'b0, i2cbe_pkg::SDA_HI,  1'b0, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd10: word = '{1'b1, i2cbe_pkg::SDA_HI,  1'b0, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd11: word = '{1'b0, i2cbe_pkg::SDA_HI,  1'b0, i2cbe_pkg::RX_ACK,  1'b1, 1'b0, 5'd0};
            // send byte: bit loop, then low clock holding the last bit
            5'd12: word = '{1'b0, i2cbe_pkg::SDA_TX,  1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd13: word = '{1'b1, i2cbe_pkg::SDA_TX,  1'b1, i2cbe_pkg::RX_NONE, 1'b0, 1'b1,
                            i2cbe_pkg::UA_SEND};
            5'd14: word = '{1'b0, i2cbe_pkg::SDA_TX,  1'b1, i2cbe_pkg::RX_NONE, 1'b1, 1'b0, 5'd0};
            // receive byte
            5'd15: word = '{1'b0, i2cbe_pkg::SDA_HI,  1'b0, i2cbe_pkg::RX_NONE, 1'b0, 1'b0, 5'd0};
            5'd16: word = '{1'b1, i2cbe_pkg::SDA_HI,  1'b0, i2cbe_pkg::RX_NONE, 1'b0, 1'b1,
                            i2cbe_pkg::UA_RECV};
            5'd17: word = '{1'b0, i2cbe_pkg::SDA_HI,  1'b0, i2cbe_pkg::RX_BYTE, 1'b1, 1'b0, 5'd0};
            default: word = '{1'b0, i2cbe_pkg::SDA_HI, 1'b0, i2cbe_pkg::RX_NONE, 1'b1, 1'b0, 5'd0};
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/i2cbe_seq.sv
// sequencer: step counter, bit loop counter and segment hold timer
// depends on i2cbe_pkg; addresses i2cbe_rom
`default_nettype none

module i2cbe_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cmd_valid,
    input  wire logic [2:0]                     cmd_req,
    input  wire logic [15:0]                    half_period,
    input  wire logic                           out_free,
    input  wire i2cbe_pkg::ucode_t              word,
    output logic [i2cbe_pkg::UADDR_W-1:0]       pc,
    output logic                                cmd_ready,
    output i2cbe_pkg::dp_ctl_t                  ctl
);

    i2cbe_pkg::seq_state_t              state_reg, state_next;
    logic [i2cbe_pkg::UADDR_W-1:0]      pc_reg, pc_next;
    logic [2:0]                         cnt_reg, cnt_next;
    logic [15:0]                        timer_reg, timer_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2cbe_pkg::SEQ_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            timer_reg <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            timer_reg <= timer_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        timer_next = timer_reg;
        ctl        = '0;
        ctl.word   = word;
        case (state_reg)
            i2cbe_pkg::SEQ_IDLE: begin
                // unknown commands are taken and dropped
                if (cmd_valid && i2cbe_pkg::req_known(cmd_req)) begin
                    ctl.load   = 1'b1;
                    pc_next    = i2cbe_pkg::req_entry(cmd_req);
                    cnt_next   = '0;
                    timer_next = half_period;
                    state_next = i2cbe_pkg::SEQ_RUN;
                end
            end
            i2cbe_pkg::SEQ_RUN: begin
                if (timer_reg > 16'd1) begin
                    timer_next = timer_reg - 16'd1;
                end else if (out_free) begin
                    ctl.emit   = 1'b1;
                    timer_next = half_period;
                    if (word.last) begin
                        state_next = i2cbe_pkg::SEQ_IDLE;
                    end else if (word.loop && cnt_reg != i2cbe_pkg::BIT_CNT_DONE) begin
                        pc_next   = word.target;
                        cnt_next  = cnt_reg + 3'd1;
                        ctl.shift = 1'b1;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            default: state_next = i2cbe_pkg::SEQ_IDLE;
        endcase
    end

    assign pc        = pc_reg;
    assign cmd_ready = (state_reg == i2cbe_pkg::SEQ_IDLE);

    a_emit_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |-> out_free)
        else $error("segment emitted into a full output register");

    a_pc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == i2cbe_pkg::SEQ_RUN |-> pc_reg <= i2cbe_pkg::UA_LAST)
        else $error("step counter left the microcode store");

    a_load_clears_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> (cnt_reg == 3'd0 && state_reg == i2cbe_pkg::SEQ_RUN))
        else $error("command start did not clear the bit counter");

    a_shift_only_looping: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.shift |-> (word.loop && ctl.emit))
        else $error("shift outside a bit loop step");

endmodule

`default_nettype wire

// File: hdl/i2cbe_datapath.sv
// datapath: command operand registers, sda select and the result register
// depends on i2cbe_pkg; driven by i2cbe_seq
`default_nettype none

module i2cbe_datapath (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire i2cbe_pkg::dp_ctl_t ctl,
    input  wire logic [7:0]   tx_byte,
    input  wire logic         ack_level,
    input  wire logic [7:0]   sda_samples,
    input  wire logic         m_tready,
    output logic              out_free,
    output logic              m_tvalid,
    output logic [15:0]       m_tdata,
    output logic              m_tlast
);

    logic [7:0]  tx_reg;
    logic [7:0]  smp_reg;
    logic        ack_reg;
    logic        m_tvalid_reg;
    logic [11:0] m_data_reg;
    logic        m_last_reg;
    logic        sda_bit;
    logic [7:0]  rx_byte;
    logic        rx_ack;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            tx_reg  <= tx_byte;
            smp_reg <= sda_samples;
            ack_reg <= ack_level;
        end else if (ctl.shift) begin
            tx_reg <= {tx_reg[6:0], 1'b0};
        end
    end

    always_comb begin
        case (ctl.word.sda_src)
            i2cbe_pkg::SDA_LO:  sda_bit = 1'b0;
            i2cbe_pkg::SDA_HI:  sda_bit = 1'b1;
            i2cbe_pkg::SDA_TX:  sda_bit = tx_reg[7];
            i2cbe_pkg::SDA_ACK: sda_bit = ack_reg;
            default:            sda_bit = 1'b1;
        endcase
        // released sda reads back as the pulled-up level
        if (!ctl.word.drive) begin
            sda_bit = 1'b1;
        end
        rx_byte = (ctl.word.rx_sel == i2cbe_pkg::RX_BYTE) ? smp_reg : 8'h00;
        rx_ack  = (ctl.word.rx_sel == i2cbe_pkg::RX_ACK) ? smp_reg[7] : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_data_reg <= {rx_ack, rx_byte, ctl.word.drive, sda_bit, ctl.word.scl};
            m_last_reg <= ctl.word.last;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: hdl/i2c_master_bit_engine.sv
// top level of the i2c master bit engine: config register, sequencer, microcode, datapath
// depends on i2cbe_pkg, i2cbe_rom, i2cbe_seq, i2cbe_datapath
`default_nettype none

// Each input beat is one bus command (start, stop, send byte, receive byte, send ack,
// receive ack) and comes out as a run of line segment beats giving scl, sda and the sda
// drive enable; the final beat of a run has tlast set and carries the received byte or
// ack. A microcode sequencer steps through one control word per segment and holds each
// segment for a time set by half_period_cycles (a value of 0 behaves as 1), counted by the
// segment hold timer, and longer while the output register is full; a command takes 3
// segments (start, stop, acks) or 17 segments (bytes). One command is worked at a time:
// s_tready is high only while the sequencer is idle, but the last segment may still wait
// in the output register while the next command is taken. Codes 6 and 7 are taken and
// dropped with no beats. Write cfg_wr_data with cfg_wr_en only while no command is in
// flight.
module i2c_master_bit_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: half_period_cycles
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tuser fields from bit 0: req_type[2:0]
    input  wire logic [2:0]  s_tuser,
    // s_tdata fields from bit 0: tx_byte[7:0], ack_level[8], sda_samples[16:9],
    // zero pad[23:17]
    input  wire logic [23:0] s_tdata,
    // segment channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata fields from bit 0: scl_level[0], sda_level[1], sda_drive[2],
    // rx_byte[10:3], rx_ack[11], zero pad[15:12]
    output logic [15:0]      m_tdata,
    // last_segment
    output logic             m_tlast
);

    logic [15:0]                   half_period_reg;
    logic [i2cbe_pkg::UADDR_W-1:0] pc;
    i2cbe_pkg::ucode_t             word;
    i2cbe_pkg::dp_ctl_t            ctl;
    logic                          out_free;
    logic                          cmd_ready;

    // segment hold length, reset to 500
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= 16'd500;
        end else if (cfg_wr_en) begin
            half_period_reg <= cfg_wr_data;
        end
    end

    i2cbe_rom u_rom (
        .addr (pc),
        .word (word)
    );

    i2cbe_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (s_tvalid),
        .cmd_req     (s_tuser),
        .half_period (half_period_reg),
        .out_free    (out_free),
        .word        (word),
        .pc          (pc),
        .cmd_ready   (cmd_ready),
        .ctl         (ctl)
    );

    i2cbe_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .tx_byte     (s_tdata[7:0]),
        .ack_level   (s_tdata[8]),
        .sda_samples (s_tdata[16:9]),
        .m_tready    (m_tready),
        .out_free    (out_free),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    assign s_tready = cmd_ready;

endmodule

`default_nettype wire
